[rtl/atan2_octant_approx_top_assert.svh]
// assertion macros for the atan2 octant approximation block
`ifndef ATAN2_OCTANT_APPROX_TOP_ASSERT_SVH
`define ATAN2_OCTANT_APPROX_TOP_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define AOA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define AOA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/aoa_pkg.sv]
// constants, types and rounding helper of the atan2 octant approximation block
`timescale 1ns / 1ps

package aoa_pkg;

    localparam int IN_W   = 16;
    localparam int FRAC_W = 16;
    localparam int FW     = IN_W + 2;
    localparam int Q_W    = FRAC_W + 1;
    localparam int D_W    = IN_W + 1;
    localparam int N_W    = IN_W + FRAC_W + 1;
    localparam int OCT_W  = 3;
    localparam int OUT_W  = 16;
    localparam int ANG_W  = 21;
    localparam int ABS_W  = 18;
    localparam int NUM_W  = 28;
    localparam int REC_W  = 30;
    localparam int PRD_W  = NUM_W + REC_W;
    localparam int M_W    = 48;
    // cubic multiplier operands and product
    localparam int MUL_W  = 18;
    localparam int PM_W   = 2 * MUL_W;

    localparam logic signed [M_W-1:0] COEF_C1 = 48'sd67509;
    localparam logic signed [M_W-1:0] COEF_C2 = -48'sd11692;
    localparam logic signed [M_W-1:0] COEF_C3 = -48'sd4345;
    localparam logic signed [MUL_W-1:0] COEF_C3_S = -18'sd4345;
    localparam logic signed [ANG_W-1:0] QPI   = 21'sd51472;
    localparam logic signed [ANG_W-1:0] PI4   = 21'sd205888;
    localparam logic signed [ANG_W-1:0] PI8   = 21'sd411776;

    // centidegrees = ang * 18000 / 205888 = ang * 1125 / 12868
    localparam logic [NUM_W-1:0] CD_MUL  = 28'd1125;
    localparam logic [NUM_W-1:0] CD_HALF = 28'd6434;
    localparam int               REC_SH  = 42;
    localparam logic [63:0]      REC_FULL = ((64'd1 << REC_SH) + 64'd12867) / 64'd12868;
    localparam logic [REC_W-1:0] CD_REC  = REC_FULL[REC_W-1:0];
    localparam logic [OUT_W-1:0] CD_MAX  = 16'd18000;

    localparam logic [OCT_W-1:0] OCT_ZERO = 3'd0;
    localparam logic [OCT_W-1:0] OCT_UP   = 3'd1;
    localparam logic [OCT_W-1:0] OCT_DOWN = 3'd6;

    typedef struct packed {
        logic [OCT_W-1:0] oct;
        logic             force_t;
        logic             t_one;
    } side_t;

    // shift right by FRAC_W, round to nearest, ties away from zero
    function automatic logic signed [M_W-1:0] round_shift(input logic signed [M_W-1:0] v);
        logic signed [M_W-1:0] mag;
        logic signed [M_W-1:0] r;
        mag = (v < 0) ? -v : v;
        r   = (mag + (48'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
        return (v < 0) ? -r : r;
    endfunction

endpackage

[rtl/atan2_octant_approx_top.sv]
// atan2 of a signed vector in centidegrees: octant fold, pipelined divider, cubic
// pipeline stages: 1 fold, 17 divider, 3 cubic, 1 angle wrap, 2 scaling, 1 output register
// throughput: one transaction per cycle while the pipeline does not hold;
// the radix-2 divider has one stage per quotient bit
// the whole pipeline holds while a result waits and m_tready is low
// reset: synchronous active-low aresetn clears all valid bits, payload is not reset
`timescale 1ns / 1ps

module atan2_octant_approx_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] y_value, [31:16] x_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] angle_centideg
);

    `include "atan2_octant_approx_top_assert.svh"

    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // ---------------- fold stage
    logic signed [aoa_pkg::FW-1:0] fy0, fx0, fy1, fx1, fy2, fx2, fy3, fx3;
    logic [aoa_pkg::OCT_W-1:0] oc1, oc2, oc3;
    aoa_pkg::side_t            side_next;
    logic [aoa_pkg::D_W-1:0]   fden_next;
    logic [aoa_pkg::D_W-1:0]   fnum_next;
    logic                      xzero;

    always_comb begin
        fy0 = aoa_pkg::FW'(signed'(s_tdata[15:0]));
        fx0 = aoa_pkg::FW'(signed'(s_tdata[31:16]));
        xzero = (s_tdata[31:16] == 16'd0);
        if (fy0 < 0) begin
            fy1 = -fy0; fx1 = -fx0; oc1 = 3'd4;
        end else begin
            fy1 = fy0;  fx1 = fx0;  oc1 = 3'd0;
        end
        if (fx1 <= 0) begin
            fx2 = fy1; fy2 = -fx1; oc2 = oc1 + 3'd2;
        end else begin
            fx2 = fx1; fy2 = fy1;  oc2 = oc1;
        end
        if (fx2 <= fy2) begin
            fx3 = fx2 + fy2; fy3 = fy2 - fx2; oc3 = oc2 + 3'd1;
        end else begin
            fx3 = fx2; fy3 = fy2; oc3 = oc2;
        end
        side_next = '{oct: oc3, force_t: 1'b0, t_one: 1'b0};
        fden_next = fx3[aoa_pkg::D_W-1:0];
        // numerator reaches 32768 on the negative x axis
        fnum_next = fy3[aoa_pkg::D_W-1:0];
        // zero x stands for a tiny positive x
        if (xzero) begin
            fden_next = aoa_pkg::D_W'(1);
            fnum_next = '0;
            if (fy0 == 0) begin
                side_next = '{oct: aoa_pkg::OCT_ZERO, force_t: 1'b1, t_one: 1'b0};
            end else if (fy0 > 0) begin
                side_next = '{oct: aoa_pkg::OCT_UP, force_t: 1'b1, t_one: 1'b1};
            end else begin
                side_next = '{oct: aoa_pkg::OCT_DOWN, force_t: 1'b1, t_one: 1'b0};
            end
        end
    end

    logic                     fv_reg;
    aoa_pkg::side_t           fside_reg;
    logic [aoa_pkg::D_W-1:0]  fden_reg;
    logic [aoa_pkg::D_W-1:0]  fnum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (ce) begin
            fv_reg <= s_tvalid;
        end
        if (ce) begin
            fside_reg <= side_next;
            fden_reg  <= fden_next;
            fnum_reg  <= fnum_next;
        end
    end

    // ---------------- divider, one quotient bit per stage
    logic [aoa_pkg::N_W-1:0] nume;
    assign nume = {fnum_reg, {aoa_pkg::FRAC_W{1'b0}}}
                + aoa_pkg::N_W'(fden_reg >> 1);

    logic                    dv_reg   [aoa_pkg::Q_W];
    aoa_pkg::side_t          dside_reg[aoa_pkg::Q_W];
    logic [aoa_pkg::D_W-1:0] dden_reg [aoa_pkg::Q_W];
    logic [aoa_pkg::D_W-1:0] drem_reg [aoa_pkg::Q_W];
    logic [aoa_pkg::Q_W-1:0] dlo_reg  [aoa_pkg::Q_W];
    logic [aoa_pkg::Q_W-1:0] dq_reg   [aoa_pkg::Q_W];

    logic [aoa_pkg::D_W-1:0] drem_next[aoa_pkg::Q_W];
    logic [aoa_pkg::Q_W-1:0] dlo_next [aoa_pkg::Q_W];
    logic [aoa_pkg::Q_W-1:0] dq_next  [aoa_pkg::Q_W];

    always_comb begin
        logic [aoa_pkg::D_W-1:0] rem_in;
        logic [aoa_pkg::Q_W-1:0] lo_in;
        logic [aoa_pkg::Q_W-1:0] q_in;
        logic [aoa_pkg::D_W-1:0] den_in;
        logic [aoa_pkg::D_W:0]   r2;
        for (int k = 0; k < aoa_pkg::Q_W; k++) begin
            if (k == 0) begin
                rem_in = aoa_pkg::D_W'(nume[aoa_pkg::N_W-1:aoa_pkg::Q_W]);
                lo_in  = nume[aoa_pkg::Q_W-1:0];
                q_in   = '0;
                den_in = fden_reg;
            end else begin
                rem_in = drem_reg[k-1];
                lo_in  = dlo_reg[k-1];
                q_in   = dq_reg[k-1];
                den_in = dden_reg[k-1];
            end
            r2 = {rem_in, lo_in[aoa_pkg::Q_W-1]};
            if (r2 >= {1'b0, den_in}) begin
                r2 = r2 - {1'b0, den_in};
                dq_next[k] = {q_in[aoa_pkg::Q_W-2:0], 1'b1};
            end else begin
                dq_next[k] = {q_in[aoa_pkg::Q_W-2:0], 1'b0};
            end
            drem_next[k] = r2[aoa_pkg::D_W-1:0];
            dlo_next[k]  = {lo_in[aoa_pkg::Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < aoa_pkg::Q_W; k++) begin
                dv_reg[k] <= 1'b0;
            end
        end else if (ce) begin
            dv_reg[0] <= fv_reg;
            for (int k = 1; k < aoa_pkg::Q_W; k++) begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end
        if (ce) begin
            dside_reg[0] <= fside_reg;
            dden_reg[0]  <= fden_reg;
            for (int k = 1; k < aoa_pkg::Q_W; k++) begin
                dside_reg[k] <= dside_reg[k-1];
                dden_reg[k]  <= dden_reg[k-1];
            end
            for (int k = 0; k < aoa_pkg::Q_W; k++) begin
                drem_reg[k] <= drem_next[k];
                dlo_reg[k]  <= dlo_next[k];
                dq_reg[k]   <= dq_next[k];
            end
        end
    end

    // ---------------- cubic, one multiply per stage
    localparam int LD = aoa_pkg::Q_W - 1;
    logic [aoa_pkg::Q_W-1:0] t_val;
    always_comb begin
        if (dside_reg[LD].force_t) begin
            t_val = dside_reg[LD].t_one ? aoa_pkg::Q_W'(1 << aoa_pkg::FRAC_W) : '0;
        end else begin
            t_val = dq_reg[LD];
        end
    end

    logic                          pv_reg  [3];
    logic [aoa_pkg::OCT_W-1:0]     poct_reg[3];
    logic [aoa_pkg::Q_W-1:0]       pt_reg  [3];
    logic signed [aoa_pkg::M_W-1:0] pacc_reg[3];
    logic signed [aoa_pkg::M_W-1:0] pacc_next[3];
    logic signed [aoa_pkg::M_W-1:0] psum1, psum2;
    logic signed [aoa_pkg::MUL_W-1:0] ts0, ts1, ts2, pc1, pc2;
    logic signed [aoa_pkg::PM_W-1:0]  pm0, pm1, pm2;

    assign ts0 = signed'({1'b0, t_val});
    assign ts1 = signed'({1'b0, pt_reg[0]});
    assign ts2 = signed'({1'b0, pt_reg[1]});
    // running sums stay within 18 signed bits for t in [0,1]
    assign psum1 = pacc_reg[0] + aoa_pkg::COEF_C2;
    assign psum2 = pacc_reg[1] + aoa_pkg::COEF_C1;
    assign pc1 = psum1[aoa_pkg::MUL_W-1:0];
    assign pc2 = psum2[aoa_pkg::MUL_W-1:0];
    assign pm0 = aoa_pkg::COEF_C3_S * ts0;
    assign pm1 = pc1 * ts1;
    assign pm2 = pc2 * ts2;
    assign pacc_next[0] = aoa_pkg::round_shift(aoa_pkg::M_W'(pm0));
    assign pacc_next[1] = aoa_pkg::round_shift(aoa_pkg::M_W'(pm1));
    assign pacc_next[2] = aoa_pkg::round_shift(aoa_pkg::M_W'(pm2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                pv_reg[k] <= 1'b0;
            end
        end else if (ce) begin
            pv_reg[0] <= dv_reg[LD];
            pv_reg[1] <= pv_reg[0];
            pv_reg[2] <= pv_reg[1];
        end
        if (ce) begin
            poct_reg[0] <= dside_reg[LD].oct;
            pt_reg[0]   <= t_val;
            poct_reg[1] <= poct_reg[0];
            pt_reg[1]   <= pt_reg[0];
            poct_reg[2] <= poct_reg[1];
            pt_reg[2]   <= pt_reg[1];
            for (int k = 0; k < 3; k++) begin
                pacc_reg[k] <= pacc_next[k];
            end
        end
    end

    // ---------------- angle, wrap above pi, magnitude
    logic signed [aoa_pkg::ANG_W-1:0] ang_raw, ang_wrap;
    always_comb begin
        ang_raw = aoa_pkg::ANG_W'(signed'({1'b0, poct_reg[2]})) * aoa_pkg::QPI
                + pacc_reg[2][aoa_pkg::ANG_W-1:0];
        ang_wrap = (ang_raw > aoa_pkg::PI4) ? ang_raw - aoa_pkg::PI8 : ang_raw;
    end

    logic                     av_reg, aneg_reg;
    logic [aoa_pkg::ABS_W-1:0] aabs_reg;
    logic                     nv_reg, nneg_reg;
    logic [aoa_pkg::NUM_W-1:0] nnum_reg;
    logic                     qv_reg, qneg_reg;
    logic [aoa_pkg::PRD_W-1:0] qprd_reg;
    logic [aoa_pkg::OUT_W-1:0] qmag;
    logic [aoa_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;
    logic                     m_tvalid_reg;

    assign qmag = (qprd_reg[aoa_pkg::PRD_W-1:aoa_pkg::REC_SH] > aoa_pkg::CD_MAX)
                ? aoa_pkg::CD_MAX : qprd_reg[aoa_pkg::REC_SH+aoa_pkg::OUT_W-1:aoa_pkg::REC_SH];
    assign m_tdata_next = qneg_reg ? -qmag : qmag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            av_reg       <= 1'b0;
            nv_reg       <= 1'b0;
            qv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            av_reg       <= pv_reg[2];
            nv_reg       <= av_reg;
            qv_reg       <= nv_reg;
            m_tvalid_reg <= qv_reg;
        end
        if (ce) begin
            aneg_reg    <= ang_wrap < 0;
            aabs_reg    <= (ang_wrap < 0) ? aoa_pkg::ABS_W'(-ang_wrap)
                                          : aoa_pkg::ABS_W'(ang_wrap);
            nneg_reg    <= aneg_reg;
            nnum_reg    <= aoa_pkg::NUM_W'(aabs_reg) * aoa_pkg::CD_MUL + aoa_pkg::CD_HALF;
            qneg_reg    <= nneg_reg;
            // exact division by the constant through its scaled reciprocal
            qprd_reg    <= aoa_pkg::PRD_W'(nnum_reg) * aoa_pkg::PRD_W'(aoa_pkg::CD_REC);
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `AOA_ASSERT_SAME(a_out_range, m_tvalid,
        ($signed(m_tdata) <= 16'sd18000) && ($signed(m_tdata) >= -16'sd18000),
        "angle out of range")
    `AOA_ASSERT_NEXT(a_enter, s_tvalid && s_tready, fv_reg,
        "accepted transaction did not enter the pipeline")
    `AOA_ASSERT_SAME(a_div_rem, dv_reg[LD], drem_reg[LD] < dden_reg[LD],
        "divider remainder not below divisor")
    `AOA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(qv_reg),
        "pipeline moved while a result was stalled")

endmodule

[verif/testbench.sv]
// testbench for the atan2 octant approximation block: directed, random and backpressure vectors
`timescale 1ns / 1ps

module testbench;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;  // [15:0] y_value, [31:16] x_value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;       // [15:0] angle_centideg

    localparam int LATENCY = 25;
    localparam int HOLD_CYCLES = 200;

    logic signed [15:0] expected_angles[$];
    int error_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_recv = 1'b0;

    atan2_octant_approx_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 aclk = ~aclk;

    // rounded shift by 16, ties away from zero
    function automatic longint rshift16(input longint v);
        if (v >= 0) return (v + 32768) >>> 16;
        return -((-v + 32768) >>> 16);
    endfunction

    function automatic logic signed [15:0] predict_angle(input logic signed [15:0] yin,
                                                         input logic signed [15:0] xin);
        longint y, x, oct, t, ang, num, cd, tmp, acc;
        y = yin;
        x = xin;
        oct = 0;
        if (x == 0) begin
            if (y == 0) begin
                oct = 0; t = 0;
            end else if (y > 0) begin
                oct = 1; t = 65536;
            end else begin
                oct = 6; t = 0;
            end
        end else begin
            if (y < 0) begin
                x = -x; y = -y; oct += 4;
            end
            if (x <= 0) begin
                tmp = x; x = y; y = -tmp; oct += 2;
            end
            if (x <= y) begin
                tmp = y - x; x = x + y; y = tmp; oct += 1;
            end
            t = ((y <<< 16) + (x >>> 1)) / x;
        end
        acc = rshift16(-4345 * t);
        acc = rshift16((acc - 11692) * t);
        acc = rshift16((acc + 67509) * t);
        ang = oct * 51472 + acc;
        if (ang > 205888) ang -= 411776;
        num = ang * 18000;
        if (num >= 0) cd = (num + 102944) / 205888;
        else cd = -((-num + 102944) / 205888);
        if (cd > 18000) cd = 18000;
        if (cd < -18000) cd = -18000;
        return cd[15:0];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch: %s got %0d expected %0d", what, got, want);
    endtask

    // valid stays high after the transaction so back to back sends need no gap
    task automatic send_vector(input logic [15:0] y, input logic [15:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {x, y};
        expected_angles.push_back(predict_angle(y, x));
        sent_count++;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    // receiver side: random stall or forced hold
    always @(posedge aclk) begin
        m_tready <= aresetn && !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            checked_count++;
            if (expected_angles.size() == 0)
                report_mismatch("unexpected transaction", $signed(m_tdata), 0);
            else begin
                logic signed [15:0] want;
                want = expected_angles.pop_front();
                if ($signed(m_tdata) !== want)
                    report_mismatch("angle_centideg", $signed(m_tdata), want);
            end
        end
    end

    task automatic drain();
        while (expected_angles.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        logic [15:0] edges[7];
        edges = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001, 16'h0064};
        // axes, diagonals, both zero and the negative x axis
        foreach (edges[i])
            for (int j = 0; j < 3; j++)
                send_vector(edges[i], edges[(i + j * 2) % 7]);
        send_vector(16'd100, 16'd100);
        send_vector(-16'sd100, -16'sd100);
        send_vector(16'd0, -16'sd5);
        send_vector(16'd5, 16'd0);
        stop_sending();
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0: send_vector(16'($urandom), 16'($urandom));
                1: send_vector(16'($urandom_range(40) - 20), 16'($urandom_range(40) - 20));
                2: begin
                    logic [15:0] v;
                    v = 16'($urandom);
                    send_vector(v, ($urandom_range(1)) ? v : -v);
                end
                default: send_vector(16'($urandom), 16'($urandom_range(3) - 1));
            endcase
        end
        stop_sending();
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv = 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_recv = 1'b0;
            end
            begin
                for (int i = 0; i < 60; i++) send_vector(16'($urandom), 16'($urandom));
                stop_sending();
            end
        join
        drain();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        drain();
        test_random(250, 0, 0);
        test_random(250, 69, 0);
        test_random(250, 0, 69);
        test_random(250, 24, 24);
        test_backpressure();
        repeat (LATENCY + 5) @(posedge aclk);
        $display("covered %0d vectors: axes, diagonals, zero, extremes, random and stalls",
                 sent_count);
        $display("%0d results checked, %0d mismatches", checked_count, error_count);
        if (error_count == 0 && expected_angles.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
